[hw/rtl/htc_pkg.sv]
// ----------------------------------------------------------------------------
// htc_pkg
// Shared codes, reset values and types of the hysteresis thermostat controller.
// ----------------------------------------------------------------------------
package htc_pkg;

	localparam int SP_W   = 11;
	localparam int TEMP_W = 16;
	localparam int STEP_W = 7;
	localparam int BAND_W = 8;
	localparam int DIG_W  = 4;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 11;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_INC    = 2'd1;
	localparam logic [1:0] OP_DEC    = 2'd2;

	localparam logic [CIDX_W-1:0] REG_STEP = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MAX  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_BAND = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET     = 7'd8;
	localparam logic [SP_W-1:0]   MAX_RESET      = 11'd800;
	localparam logic [BAND_W-1:0] BAND_RESET     = 8'd4;
	localparam logic [SP_W-1:0]   SETPOINT_RESET = 11'd336;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [SP_W-1:0]   sp_max;
		logic [BAND_W-1:0] band;
	} cfg_t;

	typedef struct packed {
		logic                     relay;
		logic [SP_W-1:0]          setpoint;
		logic signed [TEMP_W-1:0] temp;
	} state_t;

	typedef struct packed {
		logic [DIG_W-1:0] tens;
		logic [DIG_W-1:0] units;
		logic [DIG_W-1:0] tenths;
	} digits_t;

endpackage

[hw/rtl/htc_core.sv]
// ----------------------------------------------------------------------------
// htc_core
// Next-state logic: relay hysteresis on samples, saturating setpoint presses.
// ----------------------------------------------------------------------------
module htc_core (
	input  logic [1:0]                     op,
	input  logic signed [htc_pkg::TEMP_W-1:0] temp,
	input  htc_pkg::cfg_t                  cfg,
	input  htc_pkg::state_t                cur,
	output htc_pkg::state_t                nxt
);

	logic signed [htc_pkg::TEMP_W:0] t_ext;
	logic signed [htc_pkg::TEMP_W:0] lo_lim;
	logic signed [htc_pkg::TEMP_W:0] hi_lim;
	logic [htc_pkg::SP_W:0]          sp_sum;
	logic                            t_pos;

	assign t_ext  = {temp[htc_pkg::TEMP_W-1], temp};
	assign lo_lim = $signed({6'b0, cur.setpoint}) - $signed({9'b0, cfg.band});
	assign hi_lim = $signed({6'b0, cur.setpoint}) + $signed({9'b0, cfg.band});
	assign sp_sum = {1'b0, cur.setpoint} + {5'b0, cfg.step};
	assign t_pos  = !temp[htc_pkg::TEMP_W-1] && (temp != '0);

	always_comb begin
		nxt = cur;
		case (op)
			htc_pkg::OP_SAMPLE: begin
				nxt.temp = temp;
				if (!t_pos) begin
					nxt.relay = 1'b0;
				end else if (t_ext < lo_lim) begin
					nxt.relay = 1'b1;
				end else if (t_ext > hi_lim) begin
					nxt.relay = 1'b0;
				end
			end
			htc_pkg::OP_INC: begin
				if (sp_sum > {1'b0, cfg.sp_max}) begin
					nxt.setpoint = cfg.sp_max;
				end else begin
					nxt.setpoint = sp_sum[htc_pkg::SP_W-1:0];
				end
			end
			htc_pkg::OP_DEC: begin
				if (cur.setpoint < {4'b0, cfg.step}) begin
					nxt.setpoint = '0;
				end else begin
					nxt.setpoint = cur.setpoint - {4'b0, cfg.step};
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

[hw/rtl/htc_digits.sv]
// ----------------------------------------------------------------------------
// htc_digits
// Splits a magnitude in 1/16 degree into tens, units and tenths digits.
// ----------------------------------------------------------------------------
module htc_digits (
	input  logic [htc_pkg::TEMP_W-1:0] mag,
	output htc_pkg::digits_t           dig
);

	localparam logic [12:0] RECIP10 = 13'd6554;

	// Remainder modulo ten for values below 320 by a ladder of compare and subtract.
	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [8:0] r;
		logic [8:0] k;
		r = {1'b0, v};
		for (int i = 4; i >= 0; i--) begin
			k = 9'(10 << i);
			if (r >= k) begin
				r = r - k;
			end
		end
		return r[3:0];
	endfunction

	logic [11:0] whole;
	logic [24:0] prod;
	logic [7:0]  quot;
	logic [11:0] units_w;
	logic [7:0]  tenth_w;

	assign whole = mag[15:4];
	// The reciprocal is exact for every whole value the sensor can produce.
	assign prod    = 25'(whole) * 25'(RECIP10);
	assign quot    = prod[23:16];
	assign units_w = whole - ({4'b0, quot} << 3) - ({4'b0, quot} << 1);
	assign tenth_w = ({4'b0, mag[3:0]} << 3) + ({4'b0, mag[3:0]} << 1);

	assign dig.tens   = mod10(quot);
	assign dig.units  = units_w[3:0];
	assign dig.tenths = tenth_w[7:4];

endmodule

[hw/rtl/hysteresis_thermostat_controller.sv]
// ----------------------------------------------------------------------------
// hysteresis_thermostat_controller
// On/off thermostat with a dead band, button-set setpoint and decimal readout.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | op, temp_raw
//  out     | out_valid / out_stall| relay_on, setpoint_value, set_*, temp_*
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Each item is held in the input register and is then captured in the output
//  register; one item per cycle is sustained while the output is not stalled,
//  as the state update between the two registers is combinational.
//  Reset loads the setpoint of 21.0 degrees, relay off and a zero sample.
//  A stalled output holds its result while the input register takes one more.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic signed [htc_pkg::TEMP_W-1:0] temp_raw,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            relay_on,
	output logic [htc_pkg::SP_W-1:0]        setpoint_value,
	output logic [htc_pkg::DIG_W-1:0]       set_tens,
	output logic [htc_pkg::DIG_W-1:0]       set_units,
	output logic [htc_pkg::DIG_W-1:0]       set_tenths,
	output logic                            temp_negative,
	output logic [htc_pkg::DIG_W-1:0]       temp_tens,
	output logic [htc_pkg::DIG_W-1:0]       temp_units,
	output logic [htc_pkg::DIG_W-1:0]       temp_tenths,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [htc_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [htc_pkg::CDAT_W-1:0]      cfg_data
);

	htc_pkg::cfg_t   cfg_q;
	htc_pkg::state_t state_q;
	htc_pkg::state_t state_nxt;
	htc_pkg::digits_t sp_dig;
	htc_pkg::digits_t tp_dig;

	logic                             v_s1;
	logic [1:0]                       op_s1;
	logic signed [htc_pkg::TEMP_W-1:0] temp_s1;
	logic                             adv;
	logic                             accept;
	logic                             neg;
	logic [htc_pkg::TEMP_W-1:0]       mag;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && (!out_valid || !out_stall);
	assign in_stall  = v_s1 && !adv;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step   <= htc_pkg::STEP_RESET;
			cfg_q.sp_max <= htc_pkg::MAX_RESET;
			cfg_q.band   <= htc_pkg::BAND_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				htc_pkg::REG_STEP: cfg_q.step   <= cfg_data[htc_pkg::STEP_W-1:0];
				htc_pkg::REG_MAX:  cfg_q.sp_max <= cfg_data[htc_pkg::SP_W-1:0];
				htc_pkg::REG_BAND: cfg_q.band   <= cfg_data[htc_pkg::BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			temp_s1 <= temp_raw;
		end
	end

	htc_core u_core (
		.op   (op_s1),
		.temp (temp_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.relay    <= 1'b0;
			state_q.setpoint <= htc_pkg::SETPOINT_RESET;
			state_q.temp     <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// The most negative reading wraps to 0x8000, which is its true magnitude.
	assign neg = state_nxt.temp[htc_pkg::TEMP_W-1];
	assign mag = neg ? (~state_nxt.temp + 16'd1) : state_nxt.temp;

	htc_digits u_sp_digits (
		.mag ({5'b0, state_nxt.setpoint}),
		.dig (sp_dig)
	);

	htc_digits u_tp_digits (
		.mag (mag),
		.dig (tp_dig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= adv || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			relay_on       <= state_nxt.relay;
			setpoint_value <= state_nxt.setpoint;
			set_tens       <= sp_dig.tens;
			set_units      <= sp_dig.units;
			set_tenths     <= sp_dig.tenths;
			temp_negative  <= neg;
			temp_tens      <= tp_dig.tens;
			temp_units     <= tp_dig.units;
			temp_tenths    <= tp_dig.tenths;
		end
	end

`ifndef NO_ASSERTIONS
	a_inc_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == htc_pkg::OP_INC) |=> (state_q.setpoint <= cfg_q.sp_max))
		else $error("setpoint above limit after increment");

	a_cold_relay_off: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == htc_pkg::OP_SAMPLE && (temp_s1[15] || temp_s1 == '0))
		|=> (!state_q.relay && !relay_on))
		else $error("relay on after a non-positive sample");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_valid && setpoint_value == state_q.setpoint
			&& relay_on == state_q.relay))
		else $error("result register out of step with state");

	a_press_keeps_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 != htc_pkg::OP_SAMPLE) |=> $stable(state_q.temp))
		else $error("stored sample changed by a press");
`endif

endmodule
